// ===== src/swik_pkg.sv =====
// ----------------------------------------------------------------------------
// swik_pkg
// Shared types, codes and constants of the swerve inverse kinematics core.
// ----------------------------------------------------------------------------
package swik_pkg;

  localparam int MODULE_COUNT = 4;
  localparam int IDX_W        = $clog2(MODULE_COUNT);
  localparam int CORDIC_STEPS = 16;
  localparam int VW           = 20;        // wheel velocity component width
  localparam int SQ_W         = 2 * VW;    // sum of squares width
  localparam int SQRT_STEPS   = VW;        // one root bit per step
  localparam int ROOT_W       = VW;
  localparam int CW           = 44;        // CORDIC vector width
  localparam int DIV_STEPS    = 15;
  localparam int STEP_W       = 5;

  localparam logic OP_SOLVE = 1'b0;
  localparam logic OP_SEED  = 1'b1;

  localparam logic [1:0] MODE_DISABLED  = 2'd0;
  localparam logic [1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [1:0] MODE_SPIN      = 2'd2;
  localparam logic [1:0] MODE_RESERVED  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_SEEDED  = 2'd1;
  localparam logic [1:0] ST_BAD_MODE    = 2'd2;

  localparam logic [2:0] REG_POS_0     = 3'd0;
  localparam logic [2:0] REG_POS_1     = 3'd1;
  localparam logic [2:0] REG_POS_2     = 3'd2;
  localparam logic [2:0] REG_POS_3     = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_MUL_PY, DP_MUL_PX, DP_SQ_X, DP_SQ_Y, DP_SQRT_STEP,
    DP_CHECK, DP_CORDIC_STEP, DP_STORE, DP_SC_MUL, DP_DIV_STEP, DP_DIV_STORE,
    DP_FIN
  } swik_op_t;

  typedef struct packed {
    swik_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic [STEP_W-1:0]  step;
  } swik_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic err;
    logic moving;
    logic need_scale;
  } swik_stat_t;

  function automatic logic [31:0] atan_value(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:  atan_value = 32'd536870912;
      5'd1:  atan_value = 32'd316933406;
      5'd2:  atan_value = 32'd167458907;
      5'd3:  atan_value = 32'd85004756;
      5'd4:  atan_value = 32'd42667331;
      5'd5:  atan_value = 32'd21354465;
      5'd6:  atan_value = 32'd10680862;
      5'd7:  atan_value = 32'd5340245;
      5'd8:  atan_value = 32'd2670163;
      5'd9:  atan_value = 32'd1335087;
      5'd10: atan_value = 32'd667544;
      5'd11: atan_value = 32'd333772;
      5'd12: atan_value = 32'd166886;
      5'd13: atan_value = 32'd83443;
      5'd14: atan_value = 32'd41722;
      5'd15: atan_value = 32'd20861;
      5'd16: atan_value = 32'd10430;
      5'd17: atan_value = 32'd5215;
      5'd18: atan_value = 32'd2608;
      5'd19: atan_value = 32'd1304;
      5'd20: atan_value = 32'd652;
      5'd21: atan_value = 32'd326;
      5'd22: atan_value = 32'd163;
      5'd23: atan_value = 32'd81;
      default: atan_value = 32'd0;
    endcase
  endfunction

endpackage

// ===== src/swik_if.sv =====
// ----------------------------------------------------------------------------
// swik_if
// Request and result channels of the swerve inverse kinematics core.
// ----------------------------------------------------------------------------
interface swik_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [1:0]         drive_mode;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] seed_angle_0;
  logic signed [15:0] seed_angle_1;
  logic signed [15:0] seed_angle_2;
  logic signed [15:0] seed_angle_3;
  modport source (output valid, operation, drive_mode, vel_x, vel_y, yaw_rate,
                  seed_angle_0, seed_angle_1, seed_angle_2, seed_angle_3,
                  input ready);
  modport sink (input valid, operation, drive_mode, vel_x, vel_y, yaw_rate,
                seed_angle_0, seed_angle_1, seed_angle_2, seed_angle_3,
                output ready);
endinterface

interface swik_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] wheel_angle_0;
  logic signed [15:0] wheel_angle_1;
  logic signed [15:0] wheel_angle_2;
  logic signed [15:0] wheel_angle_3;
  logic [14:0]        wheel_speed_0;
  logic [14:0]        wheel_speed_1;
  logic [14:0]        wheel_speed_2;
  logic [14:0]        wheel_speed_3;
  modport source (output valid, status, wheel_angle_0, wheel_angle_1, wheel_angle_2,
                  wheel_angle_3, wheel_speed_0, wheel_speed_1, wheel_speed_2,
                  wheel_speed_3, input ready);
  modport sink (input valid, status, wheel_angle_0, wheel_angle_1, wheel_angle_2,
                wheel_angle_3, wheel_speed_0, wheel_speed_1, wheel_speed_2,
                wheel_speed_3, output ready);
endinterface

// ===== src/swerve_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_core
// Seed and rejected commands skip the solve and go straight to the result.
// A solve runs each wheel through the multiplies, squares, root, check, CORDIC
// and store on the shared root and CORDIC; a held wheel leaves the CORDIC early,
// and scaling adds a multiply and a shared divider pass per wheel. One request is
// in work at a time; the next is taken in the cycle after the result is loaded.
// Reset clears config to defaults, held angles to zero and the seeded flag.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics_core import swik_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  swik_item_if.sink    item,
  swik_result_if.source result,
  input  logic         write_enable,
  input  logic [2:0]   write_index,
  input  logic [31:0]  write_data
);

  swik_cmd_t          cmd;
  swik_stat_t         stat;
  logic signed [15:0] seed [MODULE_COUNT];
  logic signed [15:0] res_angle [MODULE_COUNT];
  logic [14:0]        res_speed [MODULE_COUNT];

  // Gather the per-module seed angles of the request.
  assign seed[0] = item.seed_angle_0;
  assign seed[1] = item.seed_angle_1;
  assign seed[2] = item.seed_angle_2;
  assign seed[3] = item.seed_angle_3;

  // The controller walks each module through wheel vector, root, angle and
  // store, then the optional scaling pass, then hands the result off. The
  // result register frees the controller to take a new request while a
  // result still waits.
  swik_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swik_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_operation (item.operation),
    .in_mode      (item.drive_mode),
    .in_vel_x     (item.vel_x),
    .in_vel_y     (item.vel_y),
    .in_yaw       (item.yaw_rate),
    .in_seed      (seed),
    .res_status   (result.status),
    .res_angle    (res_angle),
    .res_speed    (res_speed)
  );

  // Spread the result register over the result channel.
  assign result.wheel_angle_0 = res_angle[0];
  assign result.wheel_angle_1 = res_angle[1];
  assign result.wheel_angle_2 = res_angle[2];
  assign result.wheel_angle_3 = res_angle[3];
  assign result.wheel_speed_0 = res_speed[0];
  assign result.wheel_speed_1 = res_speed[1];
  assign result.wheel_speed_2 = res_speed[2];
  assign result.wheel_speed_3 = res_speed[3];

endmodule

// ===== src/swik_datapath.sv =====
// ----------------------------------------------------------------------------
// swik_datapath
// Configuration, held angles, multiplier, root, CORDIC and divider datapath.
// ----------------------------------------------------------------------------
module swik_datapath import swik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  swik_cmd_t          cmd,
  output swik_stat_t         stat,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [31:0]        write_data,
  input  logic               in_operation,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw,
  input  logic signed [15:0] in_seed [MODULE_COUNT],
  output logic [1:0]         res_status,
  output logic signed [15:0] res_angle [MODULE_COUNT],
  output logic [14:0]        res_speed [MODULE_COUNT]
);

  logic [31:0]        position [MODULE_COUNT];
  logic [14:0]        max_speed;
  logic [14:0]        threshold;
  logic signed [15:0] held [MODULE_COUNT];
  logic               seeded;

  logic               op_seed;
  logic [1:0]         mode;
  logic signed [15:0] vel_x, vel_y, yaw;

  logic signed [31:0]     prod;
  logic signed [VW-1:0]   vx, vy;
  logic [SQ_W-1:0]        sq;
  logic [SQ_W-1:0]        sv, sr;
  logic signed [CW-1:0]   cx, cy;
  logic [31:0]            cz;
  logic                   moving;
  logic signed [15:0]     ang [MODULE_COUNT];
  logic [ROOT_W-1:0]      spd [MODULE_COUNT];
  logic [ROOT_W-1:0]      largest;
  logic [34:0]            sprod;
  logic [ROOT_W-1:0]      rem;
  logic [DIV_STEPS-1:0]   quo;

  logic signed [15:0]     px, py;
  logic signed [31:0]     rnd;
  logic signed [VW-1:0]   rnd_v, base_x, base_y;
  logic signed [SQ_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]        sq_bit, trial;
  logic signed [CW-1:0]   xs, ys, sx, sy;
  logic [31:0]            z_round;
  logic [ROOT_W-1:0]      root, sel_speed;
  logic [ROOT_W-1:0]      rem_in;
  logic [5:0]             div_bit;
  logic [ROOT_W:0]        div_t;
  logic                   cmd_err;

  assign px      = position[cmd.idx][31:16];
  assign py      = position[cmd.idx][15:0];
  assign rnd     = (prod + 32'sd2048) >>> 12;
  assign rnd_v   = VW'(rnd);
  assign base_x  = (mode == MODE_TRANSLATE) ? VW'(vel_x) : '0;
  assign base_y  = (mode == MODE_TRANSLATE) ? VW'(vel_y) : '0;
  assign sqx     = SQ_W'(vx) * SQ_W'(vx);
  assign sqy     = SQ_W'(vy) * SQ_W'(vy);
  assign sq_bit  = SQ_W'(1) << {(STEP_W'(SQRT_STEPS - 1) - cmd.step), 1'b0};
  assign trial   = sr + sq_bit;
  assign root    = sr[ROOT_W-1:0];
  assign xs      = CW'(vx) <<< 20;
  assign ys      = CW'(vy) <<< 20;
  assign sx      = cx >>> cmd.step;
  assign sy      = cy >>> cmd.step;
  assign z_round = cz + 32'h0000_8000;
  assign sel_speed = moving ? root : '0;
  assign rem_in  = (cmd.step == '0) ? sprod[34:15] : rem;
  assign div_bit = 6'(DIV_STEPS - 1) - 6'(cmd.step);
  assign div_t   = {rem_in, sprod[div_bit]};
  assign cmd_err = !seeded || (mode == MODE_RESERVED);

  assign stat.is_seed    = op_seed;
  assign stat.err        = cmd_err;
  assign stat.moving     = moving;
  assign stat.need_scale = largest > ROOT_W'(max_speed);

  // Configuration and held state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MODULE_COUNT; k++) begin
        position[k] <= '0;
        held[k]     <= '0;
      end
      max_speed <= 15'd4096;
      threshold <= 15'd10;
      seeded    <= 1'b0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_POS_0:     position[0] <= write_data;
          REG_POS_1:     position[1] <= write_data;
          REG_POS_2:     position[2] <= write_data;
          REG_POS_3:     position[3] <= write_data;
          REG_MAX_SPEED: max_speed   <= write_data[14:0];
          REG_THRESHOLD: threshold   <= write_data[14:0];
          default: ;
        endcase
      end
      if (cmd.op == DP_LOAD && in_operation == OP_SEED) begin
        for (int k = 0; k < MODULE_COUNT; k++) held[k] <= in_seed[k];
        seeded <= 1'b1;
      end
      if (cmd.op == DP_FIN && !op_seed && !cmd_err) begin
        for (int k = 0; k < MODULE_COUNT; k++) held[k] <= ang[k];
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_seed <= in_operation;
        mode    <= in_mode;
        vel_x   <= in_vel_x;
        vel_y   <= in_vel_y;
        yaw     <= in_yaw;
        largest <= '0;
      end
      DP_MUL_PY: prod <= yaw * py;
      DP_MUL_PX: begin
        vx   <= (mode == MODE_DISABLED) ? '0 : base_x - rnd_v;
        prod <= yaw * px;
      end
      DP_SQ_X: begin
        vy <= (mode == MODE_DISABLED) ? '0 : base_y + rnd_v;
        sq <= SQ_W'(sqx);
      end
      DP_SQ_Y: begin
        sv <= sq + SQ_W'(sqy);
        sr <= '0;
      end
      DP_SQRT_STEP: begin
        if (sv >= trial) begin
          sv <= sv - trial;
          sr <= (sr >> 1) + sq_bit;
        end else begin
          sr <= sr >> 1;
        end
      end
      DP_CHECK: begin
        moving <= root > ROOT_W'(threshold);
        if (vx < 0) begin
          if (vy >= 0) begin
            cx <= ys;
            cy <= -xs;
            cz <= 32'h4000_0000;
          end else begin
            cx <= -ys;
            cy <= xs;
            cz <= 32'hC000_0000;
          end
        end else begin
          cx <= xs;
          cy <= ys;
          cz <= '0;
        end
      end
      DP_CORDIC_STEP: begin
        if (cy >= 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + atan_value(cmd.step);
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - atan_value(cmd.step);
        end
      end
      DP_STORE: begin
        ang[cmd.idx] <= moving ? z_round[31:16] : held[cmd.idx];
        spd[cmd.idx] <= sel_speed;
        if (sel_speed > largest) largest <= sel_speed;
      end
      DP_SC_MUL: sprod <= 35'(spd[cmd.idx]) * 35'(max_speed);
      DP_DIV_STEP: begin
        if (div_t >= {1'b0, largest}) begin
          rem <= ROOT_W'(div_t - {1'b0, largest});
          quo <= {quo[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem <= div_t[ROOT_W-1:0];
          quo <= {quo[DIV_STEPS-2:0], 1'b0};
        end
      end
      DP_DIV_STORE: spd[cmd.idx] <= ROOT_W'(quo);
      DP_FIN: begin
        for (int k = 0; k < MODULE_COUNT; k++) begin
          if (op_seed) begin
            res_angle[k] <= held[k];
            res_speed[k] <= '0;
          end else if (cmd_err) begin
            res_angle[k] <= '0;
            res_speed[k] <= '0;
          end else begin
            res_angle[k] <= ang[k];
            res_speed[k] <= spd[k][14:0];
          end
        end
        if (op_seed)      res_status <= ST_OK;
        else if (!seeded) res_status <= ST_NOT_SEEDED;
        else if (cmd_err) res_status <= ST_BAD_MODE;
        else              res_status <= ST_OK;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/swik_controller.sv =====
// ----------------------------------------------------------------------------
// swik_controller
// Sequencer for the per-module solve, the speed scaling and the result hand-off.
// ----------------------------------------------------------------------------
module swik_controller import swik_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  swik_stat_t stat,
  output swik_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL_PY, S_MUL_PX, S_SQ_X, S_SQ_Y, S_SQRT, S_CHECK,
    S_CORDIC, S_STORE, S_SCALE_CHK, S_SC_MUL, S_DIV, S_DIV_STORE, S_FIN
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [STEP_W-1:0] step;
  logic              out_free;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MODULE_COUNT - 1);

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.idx  = idx;
    cmd.step = step;
    case (state)
      S_IDLE:      cmd.op = in_valid ? DP_LOAD : DP_NONE;
      S_MUL_PY:    cmd.op = DP_MUL_PY;
      S_MUL_PX:    cmd.op = DP_MUL_PX;
      S_SQ_X:      cmd.op = DP_SQ_X;
      S_SQ_Y:      cmd.op = DP_SQ_Y;
      S_SQRT:      cmd.op = DP_SQRT_STEP;
      S_CHECK:     cmd.op = DP_CHECK;
      S_CORDIC:    cmd.op = DP_CORDIC_STEP;
      S_STORE:     cmd.op = DP_STORE;
      S_SC_MUL:    cmd.op = DP_SC_MUL;
      S_DIV:       cmd.op = DP_DIV_STEP;
      S_DIV_STORE: cmd.op = DP_DIV_STORE;
      S_FIN:       cmd.op = out_free ? DP_FIN : DP_NONE;
      default:     cmd.op = DP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          idx <= '0;
          state <= (stat.is_seed || stat.err) ? S_FIN : S_MUL_PY;
        end
        S_MUL_PY: state <= S_MUL_PX;
        S_MUL_PX: state <= S_SQ_X;
        S_SQ_X:   state <= S_SQ_Y;
        S_SQ_Y: begin
          step  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(SQRT_STEPS - 1)) state <= S_CHECK;
        end
        S_CHECK: begin
          step  <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          step <= step + 1'b1;
          // Skip the rotation for a wheel that holds its angle.
          if (!stat.moving || step == STEP_W'(CORDIC_STEPS - 1)) state <= S_STORE;
        end
        S_STORE: begin
          if (idx == LAST_IDX) begin
            state <= S_SCALE_CHK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL_PY;
          end
        end
        S_SCALE_CHK: begin
          idx   <= '0;
          state <= stat.need_scale ? S_SC_MUL : S_FIN;
        end
        S_SC_MUL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) state <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (idx == LAST_IDX) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SC_MUL;
          end
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/swerve_inverse_kinematics_core_tb.sv =====
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_core_tb
// Self-checking bench: drives seed and solve requests with random idling on
// both channels, predicts every result with an independent fixed-point model
// (root, CORDIC, speed scaling, held angles) and compares in order.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics_core_tb;
  import swik_pkg::*;

  typedef struct {
    logic               op;
    logic [1:0]         mode;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic [15:0]        seed [4];
  } ik_request_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] angle [4];
    logic [14:0] speed [4];
  } wheel_cmd_t;

  // Kinematics predictor and in-order store of expected wheel commands.
  class wheel_cmd_scoreboard;
    logic [31:0] pos [4];
    logic [14:0] max_speed;
    logic [14:0] threshold;
    logic [15:0] held [4];
    bit          seeded;
    wheel_cmd_t  pending_cmds [$];
    int          mismatches;
    logic [31:0] atan_lut [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

    function void clear_state();
      foreach (pos[k]) begin
        pos[k]  = '0;
        held[k] = '0;
      end
      max_speed  = 15'd4096;
      threshold  = 15'd10;
      seeded     = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_POS_0, REG_POS_1, REG_POS_2, REG_POS_3: pos[idx[1:0]] = data;
        REG_MAX_SPEED: max_speed = data[14:0];
        REG_THRESHOLD: threshold = data[14:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [15:0] heading(longint x, longint y);
      logic [31:0] z;
      logic [32:0] rounded;
      longint t, xs, ys;
      z = '0;
      x = x <<< 20;
      y = y <<< 20;
      // fold the left half-plane onto the right one
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = 32'h4000_0000;
        end else begin
          x = -y;
          y = t;
          z = 32'hC000_0000;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += atan_lut[i];
        end else begin
          x -= ys;
          y += xs;
          z -= atan_lut[i];
        end
      end
      rounded = {1'b0, z} + 33'h8000;
      return rounded[31:16];
    endfunction

    function void note_request(ik_request_t rq);
      wheel_cmd_t      c;
      longint          px, py, w, wx, wy;
      longint unsigned s, largest;
      longint unsigned spd [4];
      c.status = ST_OK;
      foreach (c.angle[k]) begin
        c.angle[k] = '0;
        c.speed[k] = '0;
      end
      if (rq.op == OP_SEED) begin
        foreach (held[k]) begin
          held[k]    = rq.seed[k];
          c.angle[k] = rq.seed[k];
        end
        seeded = 1;
      end else if (!seeded) begin
        c.status = ST_NOT_SEEDED;
      end else if (rq.mode == MODE_RESERVED) begin
        c.status = ST_BAD_MODE;
      end else begin
        largest = 0;
        w = rq.yaw;
        for (int k = 0; k < 4; k++) begin
          px = $signed(pos[k][31:16]);
          py = $signed(pos[k][15:0]);
          wx = 0;
          wy = 0;
          if (rq.mode != MODE_DISABLED) begin
            if (rq.mode == MODE_TRANSLATE) begin
              wx = rq.vx;
              wy = rq.vy;
            end
            wx -= (w * py + 2048) >>> 12;
            wy += (w * px + 2048) >>> 12;
          end
          s = root_floor(wx * wx + wy * wy);
          if (s <= threshold) begin
            c.angle[k] = held[k];
            spd[k] = 0;
          end else begin
            c.angle[k] = heading(wx, wy);
            spd[k] = s;
          end
          if (spd[k] > largest) largest = spd[k];
        end
        for (int k = 0; k < 4; k++) begin
          if (largest > max_speed) spd[k] = spd[k] * max_speed / largest;
          c.speed[k] = spd[k][14:0];
          held[k]    = c.angle[k];
        end
      end
      pending_cmds.push_back(c);
    endfunction

    function void check_result(wheel_cmd_t got);
      wheel_cmd_t exp;
      bit bad;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", got.status);
        return;
      end
      exp = pending_cmds.pop_front();
      bad = (exp.status != got.status);
      foreach (exp.angle[k])
        bad |= (exp.angle[k] != got.angle[k]) || (exp.speed[k] != got.speed[k]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp st %0d ang %p spd %p / got st %0d ang %p spd %p",
                   exp.status, exp.angle, exp.speed, got.status, got.angle, got.speed);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [2:0]  write_index;
  logic [31:0] write_data;

  swik_item_if   item_ch ();
  swik_result_if result_ch ();

  swerve_inverse_kinematics_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  wheel_cmd_scoreboard sb = new();
  bit steady;          // phase with no idling on either side
  int hold_off_len;    // pending long receiver hold-off, consumed by the ready process
  int ready_gap;       // remaining cycles of the current random receiver gap
  int idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Pick an idle gap: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 70);
  endfunction

  // Result side: random ready gaps, with a long hold-off when requested.
  always @(posedge clk) begin
    int g;
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_gap       <= 0;
    end else if (hold_off_len > 0) begin
      result_ch.ready <= 1'b0;
      hold_off_len    <= hold_off_len - 1;
    end else if (ready_gap > 0) begin
      result_ch.ready <= 1'b0;
      ready_gap       <= ready_gap - 1;
    end else begin
      g = pick_gap();
      result_ch.ready <= (g == 0);
      if (g > 0) ready_gap <= g - 1;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    wheel_cmd_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status   = result_ch.status;
      got.angle[0] = result_ch.wheel_angle_0;
      got.angle[1] = result_ch.wheel_angle_1;
      got.angle[2] = result_ch.wheel_angle_2;
      got.angle[3] = result_ch.wheel_angle_3;
      got.speed[0] = result_ch.wheel_speed_0;
      got.speed[1] = result_ch.wheel_speed_1;
      got.speed[2] = result_ch.wheel_speed_2;
      got.speed[3] = result_ch.wheel_speed_3;
      sb.check_result(got);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("swerve_inverse_kinematics_core_tb NOT OK");
      $finish;
    end
  end

  // Offer one request and hold it until accepted; called right after a rising edge.
  task automatic send_request(ik_request_t rq);
    int g;
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= rq.op;
    item_ch.drive_mode   <= rq.mode;
    item_ch.vel_x        <= rq.vx;
    item_ch.vel_y        <= rq.vy;
    item_ch.yaw_rate     <= rq.yaw;
    item_ch.seed_angle_0 <= rq.seed[0];
    item_ch.seed_angle_1 <= rq.seed[1];
    item_ch.seed_angle_2 <= rq.seed[2];
    item_ch.seed_angle_3 <= rq.seed[3];
    do @(posedge clk); while (!item_ch.ready);
    sb.note_request(rq);
    g = pick_gap();
    if (g > 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop valid, then wait for every expected result plus the solve latency.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ik_request_t make_req(logic op, logic [1:0] mode, int vx, int vy,
                                           int yaw);
    ik_request_t rq;
    rq.op   = op;
    rq.mode = mode;
    rq.vx   = 16'(vx);
    rq.vy   = 16'(vy);
    rq.yaw  = 16'(yaw);
    foreach (rq.seed[k]) rq.seed[k] = 16'($urandom());
    return rq;
  endfunction

  function automatic int rand_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed(16'($urandom()));
    if (r < 8) return $signed(16'($urandom_range(0, 40))) - 20;
    if (r < 9) return 0;
    return ($urandom_range(0, 1)) ? 32767 : -32768;
  endfunction

  function automatic logic [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'h7FFF_7FFF;
    if (r == 1) return 32'h8000_8000;
    if (r == 2) return {16'($signed(16'($urandom_range(0, 4000))) - 2000),
                        16'($signed(16'($urandom_range(0, 4000))) - 2000)};
    return $urandom();
  endfunction

  initial begin
    ik_request_t rq;
    int r;
    sb.clear_state();
    steady        = 0;
    hold_off_len  = 0;
    idle_cycles   = 0;
    rst           <= 1'b1;
    write_enable  <= 1'b0;
    write_index   <= '0;
    write_data    <= '0;
    item_ch.valid <= 1'b0;
    item_ch.operation    <= OP_SOLVE;
    item_ch.drive_mode   <= MODE_DISABLED;
    item_ch.vel_x        <= '0;
    item_ch.vel_y        <= '0;
    item_ch.yaw_rate     <= '0;
    item_ch.seed_angle_0 <= '0;
    item_ch.seed_angle_1 <= '0;
    item_ch.seed_angle_2 <= '0;
    item_ch.seed_angle_3 <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: commands before seeding are refused, then seed with extremes.
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 1000, 0, 0));
    send_request(make_req(OP_SOLVE, MODE_RESERVED, 0, 0, 0));
    rq = make_req(OP_SEED, MODE_RESERVED, -1, -1, -1);
    rq.seed = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    send_request(rq);
    send_request(make_req(OP_SOLVE, MODE_RESERVED, 500, 500, 500));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 0, 0, 0));    // all wheels hold
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 32767, 32767, 0));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, -2000, 0, 0)); // heading wraps at pi
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, -32768, -32768, 0));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 0, -3000, 0));
    drain();

    // Directed with a spread chassis and a tight limit.
    write_reg(REG_POS_0, {16'sd1200, 16'sd1200});
    write_reg(REG_POS_1, {16'sd1200, -16'sd1200});
    write_reg(REG_POS_2, {-16'sd1200, 16'sd1200});
    write_reg(REG_POS_3, {-16'sd1200, -16'sd1200});
    write_reg(REG_MAX_SPEED, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    send_request(make_req(OP_SOLVE, MODE_DISABLED, 3000, 3000, 3000));
    send_request(make_req(OP_SOLVE, MODE_SPIN, 3000, -3000, 4000));
    send_request(make_req(OP_SOLVE, MODE_SPIN, 0, 0, -32768));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 5000, -7000, 32767));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 1, 0, 0));
    drain();
    write_reg(REG_MAX_SPEED, 32'd32767);
    write_reg(REG_THRESHOLD, 32'd32767);
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 32767, 32767, 32767));
    send_request(make_req(OP_SOLVE, MODE_TRANSLATE, 100, 100, 0));
    drain();

    // Random phases, each under fresh register settings.
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 4; k++) write_reg(3'(REG_POS_0 + k), rand_pos());
      r = $urandom_range(0, 3);
      write_reg(REG_MAX_SPEED, (r == 0) ? 32'd1 : (r == 1) ? 32'd32767
                                : 32'($urandom_range(1, 32767)));
      r = $urandom_range(0, 3);
      write_reg(REG_THRESHOLD, (r == 0) ? 32'd0 : (r == 1) ? 32'd32767
                                : 32'($urandom_range(0, 60)));
      steady = (ph == 2);
      for (int n = 0; n < 85; n++) begin
        // Hold the receiver off for a long stretch so the core stalls its input.
        if (ph == 1 && n == 10) hold_off_len = 1500;
        r = $urandom_range(0, 99);
        if (r < 8)
          rq = make_req(OP_SEED, 2'($urandom()), rand_vel(), rand_vel(), rand_vel());
        else if (r < 14)
          rq = make_req(OP_SOLVE, MODE_RESERVED, rand_vel(), rand_vel(), rand_vel());
        else
          rq = make_req(OP_SOLVE, 2'($urandom_range(0, 2)), rand_vel(), rand_vel(),
                        rand_vel());
        send_request(rq);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
      $display("swerve_inverse_kinematics_core_tb OK");
    else
      $display("swerve_inverse_kinematics_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== swerve_inverse_kinematics_core.f =====
src/swik_pkg.sv
src/swik_if.sv
src/swik_datapath.sv
src/swik_controller.sv
src/swerve_inverse_kinematics_core.sv
tb/sv/swerve_inverse_kinematics_core_tb.sv
